// ===== hdl/nfk_pkg.sv =====
// Package for the number-format kind classifier.
// Holds character codes, the result kind codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package nfk_pkg;

  localparam logic [7:0] CH_M         = 8'h6D;
  localparam logic [7:0] CH_H         = 8'h68;
  localparam logic [7:0] CH_S         = 8'h73;
  localparam logic [7:0] CH_Y         = 8'h79;
  localparam logic [7:0] CH_D         = 8'h64;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_UPPER_R   = 8'h52;
  localparam logic [7:0] CH_E         = 8'h65;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  // Oldest byte in the high position, matching the history register.
  localparam logic [23:0] RED_PREFIX = {CH_LBRACKET, CH_UPPER_R, CH_E};

  typedef enum logic [1:0] {
    KIND_NUMBER    = 2'd0,
    KIND_DATE      = 2'd1,
    KIND_TIME      = 2'd2,
    KIND_DATE_TIME = 2'd3
  } kind_t;

  // One character of the format code as it moves into the scanner.
  typedef struct packed {
    logic       step;
    logic [7:0] code;
    logic       last;
  } char_t;

endpackage

// ===== hdl/nfk_scan.sv =====
// Character scanner of the number-format kind classifier.
// Holds the escape, quote and letter flags and gives the kind on the last item.
// Depends on nfk_pkg.
`timescale 1ns / 1ps

module nfk_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  nfk_pkg::char_t chr,
  output nfk_pkg::kind_t kind
);

  logic        quote_open_r, quote_open_nxt;
  logic        bs_odd_r, bs_odd_nxt;
  logic [23:0] prev_r, prev_nxt;
  logic        pend_d_r, pend_d_nxt;
  logic        pend_ctx_r, pend_ctx_nxt;
  logic        seen_m_r, seen_m_nxt;
  logic        seen_date_r, seen_date_nxt;
  logic        seen_time_r, seen_time_nxt;

  logic       is_letter;
  logic       escaped;
  logic       red_d;
  logic       count_it;
  logic       fin_date;

  always_comb begin
    is_letter = (chr.code == nfk_pkg::CH_M) || (chr.code == nfk_pkg::CH_H) ||
                (chr.code == nfk_pkg::CH_S) || (chr.code == nfk_pkg::CH_Y) ||
                (chr.code == nfk_pkg::CH_D);
    // A backslash right before the letter decides alone; otherwise the quote does.
    escaped = (prev_r[7:0] == nfk_pkg::CH_BACKSLASH) ? bs_odd_r : quote_open_r;
    red_d   = (chr.code == nfk_pkg::CH_D) && (prev_r == nfk_pkg::RED_PREFIX);
    count_it = is_letter && !red_d && !escaped;

    seen_m_nxt    = seen_m_r || (count_it && (chr.code == nfk_pkg::CH_M));
    seen_time_nxt = seen_time_r || (count_it &&
                    ((chr.code == nfk_pkg::CH_H) || (chr.code == nfk_pkg::CH_S)));
    seen_date_nxt = seen_date_r ||
                    (pend_d_r && pend_ctx_r && (chr.code != nfk_pkg::CH_RBRACKET)) ||
                    (count_it && ((chr.code == nfk_pkg::CH_Y) ||
                                  (chr.code == nfk_pkg::CH_D)));
    pend_d_nxt    = is_letter && red_d;
    pend_ctx_nxt  = is_letter && red_d && !escaped;

    quote_open_nxt = quote_open_r ^ (chr.code == nfk_pkg::CH_QUOTE);
    bs_odd_nxt     = (chr.code == nfk_pkg::CH_BACKSLASH) ? !bs_odd_r : 1'b0;
    prev_nxt       = {prev_r[15:0], chr.code};

    // A red-marker d that ends the code still counts.
    fin_date = seen_date_nxt || (pend_d_nxt && pend_ctx_nxt);
    if (fin_date && seen_time_nxt) begin
      kind = nfk_pkg::KIND_DATE_TIME;
    end else if (seen_time_nxt) begin
      kind = nfk_pkg::KIND_TIME;
    end else if (fin_date || seen_m_nxt) begin
      kind = nfk_pkg::KIND_DATE;
    end else begin
      kind = nfk_pkg::KIND_NUMBER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (chr.step && chr.last)) begin
      quote_open_r <= 1'b0;
      bs_odd_r     <= 1'b0;
      prev_r       <= '0;
      pend_d_r     <= 1'b0;
      pend_ctx_r   <= 1'b0;
      seen_m_r     <= 1'b0;
      seen_date_r  <= 1'b0;
      seen_time_r  <= 1'b0;
    end else if (chr.step) begin
      quote_open_r <= quote_open_nxt;
      bs_odd_r     <= bs_odd_nxt;
      prev_r       <= prev_nxt;
      pend_d_r     <= pend_d_nxt;
      pend_ctx_r   <= pend_ctx_nxt;
      seen_m_r     <= seen_m_nxt;
      seen_date_r  <= seen_date_nxt;
      seen_time_r  <= seen_time_nxt;
    end
  end

endmodule

// ===== hdl/number_format_kind_classifier.sv =====
// A result is registered once its last character leaves the input register.
// Throughput: one character per cycle; only a stalled result holds the input.
// The input register feeds the scanner, which writes the result register.
// Reset (rst_n low, synchronous) empties both registers and clears all flags.
// Depends on nfk_pkg and nfk_scan.
`timescale 1ns / 1ps

module number_format_kind_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_value_kind
);

  logic           s1_valid_r;
  logic [7:0]     s1_code_r;
  logic           s1_last_r;
  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic           out_free;
  logic           s1_adv;
  nfk_pkg::char_t chr;
  nfk_pkg::kind_t kind;

  assign out_free = !out_valid_r || !out_stall;
  // Characters that are not last leave no result and never wait.
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  assign chr.step = s1_adv;
  assign chr.code = s1_code_r;
  assign chr.last = s1_last_r;

  nfk_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .chr   (chr),
    .kind  (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_code_r <= in_char_code;
      s1_last_r <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_last_r) begin
      out_kind_r <= kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_kind = out_kind_r;

endmodule

// ===== hdl/nfk_checker.sv =====
// Port-level checks for the number-format kind classifier, with its bind.
// Depends on number_format_kind_classifier.
`timescale 1ns / 1ps

module nfk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_value_kind
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_kind))
    else $error("result changed while stalled");

  // The input waits only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Reset leaves both sides empty.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // A new result cannot appear without an item having come in.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n) && !$past(out_valid) && $past(!in_stall))
    else $error("result appeared unexpectedly");

endmodule

bind number_format_kind_classifier nfk_checker u_nfk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_value_kind (out_value_kind)
);
